/* sv/uf_cnt_pkg.sv */
// Shared constants for the union-find component counter.
// No dependencies; used by union_find_component_counter_top.
package uf_cnt_pkg;

    // Default node table depth
    parameter int MAX_NODES_DEF = 1024;

    // Field widths
    localparam int NODE_W  = 10;
    localparam int COUNT_W = 11;
    localparam int LINKS_W = 10;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_NODE_COUNT = 2'd0;

    // Reset and limit values
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;
    localparam logic [COUNT_W-1:0] MERGE_LIMIT      = 11'd2047;
    localparam logic [LINKS_W-1:0] LINKS_MAX        = 10'd1023;

    // Action codes
    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_EDGE  = 1'b1;

endpackage

/* sv/union_find_component_counter_top.sv */
// Union-find component counter: parent memory, root walks with path compression.
// Depends on uf_cnt_pkg.
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------
// input    | in        | in_valid/in_stall  | action, node_a, node_b
// output   | out       | out_valid/out_stall| merged, links_needed
// config   | in        | APB (psel/penable) | node_count at byte address 0
//
// Edge item: the walk from node_a (S_FIND) and its compression (S_COMP), then the
// same for node_b, then the link and the result state; one memory read per walk
// step, a read and a write per compression step. An edge outside the table goes
// straight to the result state. Clear item: memory sweep, then the result state.
// Reset runs the same sweep; in_stall is high until done.
// One item at a time; the next is taken in the cycle after the result is loaded,
// and a stalled full output register keeps the finished result in the result state.
module union_find_component_counter_top #(
    parameter int MAX_NODES = uf_cnt_pkg::MAX_NODES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [uf_cnt_pkg::NODE_W-1:0]         node_a,
    input  logic [uf_cnt_pkg::NODE_W-1:0]         node_b,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  merged,
    output logic [uf_cnt_pkg::LINKS_W-1:0]        links_needed,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [uf_cnt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [uf_cnt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [uf_cnt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_COMP,
        S_RESULT
    } state_t;

    // Control and datapath registers
    state_t                              state_reg, state_next;
    logic [IDX_W-1:0]                    clr_idx_reg, clr_idx_next;
    logic                                clr_item_reg, clr_item_next;
    logic                                phase_reg, phase_next;
    logic [IDX_W-1:0]                    a_reg, a_next;
    logic [IDX_W-1:0]                    b_reg, b_next;
    logic [IDX_W-1:0]                    cur_reg, cur_next;
    logic [IDX_W-1:0]                    root_reg, root_next;
    logic [IDX_W-1:0]                    root_a_reg, root_a_next;
    logic                                hit_reg, hit_next;
    logic [uf_cnt_pkg::COUNT_W-1:0]      merge_reg, merge_next;
    logic [uf_cnt_pkg::COUNT_W-1:0]      node_count_reg, node_count_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                merged_reg, merged_next;
    logic [uf_cnt_pkg::LINKS_W-1:0]      links_reg, links_next;

    // Parent memory ports
    logic [IDX_W-1:0] parent_mem [MAX_NODES];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] rd_data_reg;

    logic             out_load;
    logic             in_range;
    logic             cfg_write;
    logic [uf_cnt_pkg::COUNT_W-1:0] need;
    logic [uf_cnt_pkg::LINKS_W-1:0] links_calc;

    // Synchronous parent memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            parent_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= parent_mem[mem_raddr];
        end
    end

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == uf_cnt_pkg::ADDR_NODE_COUNT)
                     ? {{(uf_cnt_pkg::APB_DATA_W - uf_cnt_pkg::COUNT_W){1'b0}}, node_count_reg}
                     : '0;

    always_comb
    begin
        node_count_next = node_count_reg;
        if (cfg_write && paddr == uf_cnt_pkg::ADDR_NODE_COUNT)
        begin
            node_count_next = pwdata[uf_cnt_pkg::COUNT_W-1:0];
        end
    end

    // Endpoints must lie inside the table
    assign in_range = (32'(node_a) < 32'(MAX_NODES)) && (32'(node_b) < 32'(MAX_NODES));

    // Remaining links: node_count - 1 - merges, floored at 0, capped
    always_comb
    begin
        need = '0;
        if (node_count_reg > merge_reg)
        begin
            need = node_count_reg - merge_reg - uf_cnt_pkg::COUNT_W'(1);
        end
        links_calc = (need > {1'b0, uf_cnt_pkg::LINKS_MAX})
                   ? uf_cnt_pkg::LINKS_MAX
                   : need[uf_cnt_pkg::LINKS_W-1:0];
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_RESULT) && (!out_valid_reg || !out_stall);

    // Sequencer: clear sweep, root walk, compression, link
    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        clr_item_next = clr_item_reg;
        phase_next    = phase_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        cur_next      = cur_reg;
        root_next     = root_reg;
        root_a_next   = root_a_reg;
        hit_next      = hit_reg;
        merge_next    = merge_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_reg;
        mem_wdata     = root_reg;
        mem_re        = 1'b0;
        mem_raddr     = cur_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // point each entry at itself
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = clr_idx_reg;
                if (clr_idx_reg == LAST_IDX)
                begin
                    clr_idx_next = '0;
                    state_next   = clr_item_reg ? S_RESULT : S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    hit_next = 1'b0;
                    if (action == uf_cnt_pkg::ACT_CLEAR)
                    begin
                        clr_item_next = 1'b1;
                        clr_idx_next  = '0;
                        merge_next    = '0;
                        state_next    = S_CLEAR;
                    end
                    else if (in_range)
                    begin
                        a_next     = IDX_W'(node_a);
                        b_next     = IDX_W'(node_b);
                        cur_next   = IDX_W'(node_a);
                        phase_next = 1'b0;
                        mem_re     = 1'b1;
                        mem_raddr  = IDX_W'(node_a);
                        state_next = S_FIND;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_FIND:
            begin
                if (rd_data_reg == cur_reg)
                begin
                    // root found; restart at the endpoint to compress
                    root_next  = cur_reg;
                    cur_next   = phase_reg ? b_reg : a_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = phase_reg ? b_reg : a_reg;
                    state_next = S_COMP;
                end
                else
                begin
                    cur_next  = rd_data_reg;
                    mem_re    = 1'b1;
                    mem_raddr = rd_data_reg;
                end
            end
            S_COMP:
            begin
                if (cur_reg == root_reg)
                begin
                    if (!phase_reg)
                    begin
                        // advance to the walk from node_b
                        root_a_next = root_reg;
                        phase_next  = 1'b1;
                        cur_next    = b_reg;
                        mem_re      = 1'b1;
                        mem_raddr   = b_reg;
                        state_next  = S_FIND;
                    end
                    else
                    begin
                        // link the first root under the second
                        if (root_a_reg != root_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = root_a_reg;
                            mem_wdata = root_reg;
                            hit_next  = 1'b1;
                            if (merge_reg != uf_cnt_pkg::MERGE_LIMIT)
                            begin
                                merge_next = merge_reg + uf_cnt_pkg::COUNT_W'(1);
                            end
                        end
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    // point this node at the root and step on
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg;
                    mem_wdata = root_reg;
                    cur_next  = rd_data_reg;
                    mem_re    = 1'b1;
                    mem_raddr = rd_data_reg;
                end
            end
            S_RESULT:
            begin
                if (out_load)
                begin
                    clr_item_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop it on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        merged_next    = merged_reg;
        links_next     = links_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            merged_next    = hit_reg;
            links_next     = links_calc;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            clr_item_reg   <= 1'b0;
            phase_reg      <= 1'b0;
            a_reg          <= '0;
            b_reg          <= '0;
            cur_reg        <= '0;
            root_reg       <= '0;
            root_a_reg     <= '0;
            hit_reg        <= 1'b0;
            merge_reg      <= '0;
            node_count_reg <= uf_cnt_pkg::NODE_COUNT_RESET;
            out_valid_reg  <= 1'b0;
            merged_reg     <= 1'b0;
            links_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            clr_item_reg   <= clr_item_next;
            phase_reg      <= phase_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            cur_reg        <= cur_next;
            root_reg       <= root_next;
            root_a_reg     <= root_a_next;
            hit_reg        <= hit_next;
            merge_reg      <= merge_next;
            node_count_reg <= node_count_next;
            out_valid_reg  <= out_valid_next;
            merged_reg     <= merged_next;
            links_reg      <= links_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign merged       = merged_reg;
    assign links_needed = links_reg;

    // A read and a write never hit the same entry in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("parent memory read and write collide");

    // The merge count only steps up by one or clears
    assert property (@(posedge clk) disable iff (!rst_n)
        (merge_reg != $past(merge_reg)) |->
            (merge_reg == $past(merge_reg) + uf_cnt_pkg::COUNT_W'(1)) || (merge_reg == '0))
        else $error("merge count jumped");

    // A new result appears only after the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> ($past(state_reg) == S_RESULT))
        else $error("result produced outside the result state");

    // A merge is reported only when the two roots differed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && hit_reg) |-> (root_a_reg != root_reg))
        else $error("merge flagged with equal roots");

endmodule
